### rtl/core/sdpm_pkg.sv
// ----------------------------------------------------------------------------
// sdpm_pkg
// Shared types and helpers for the stereo pixel match core: controller
// state, command and status bundles, and the RGB to gray conversion.
// ----------------------------------------------------------------------------
package sdpm_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // take the item into the windows
		logic step;    // compare one window entry
		logic emit;    // load result register, drop oldest pixel
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;  // the offered item completes a window or ends the frame
		logic scan_last;  // current compare is the last of the window
		logic more;       // more pixels remain to flush after this result
	} dp_stat_t;

	localparam int unsigned GRAY_RECIP = 683;  // ceil(2^11 / 3)
	localparam int unsigned GRAY_SHIFT = 11;

	// floor((a+b+c)/3) as a multiply by a reciprocal; exact for sums up to 765.
	function automatic logic [7:0] gray_of(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = 10'(a) + 10'(b) + 10'(c);
		prod = 20'(sum) * 20'(GRAY_RECIP);
		return prod[GRAY_SHIFT +: 8];
	endfunction

endpackage

### rtl/core/sdpm_pix_if.sv
// ----------------------------------------------------------------------------
// sdpm_pix_if
// Pixel pair channel: one left and one right RGB pixel plus frame end mark.
// ----------------------------------------------------------------------------
interface sdpm_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_ch0;
	logic [7:0] left_ch1;
	logic [7:0] left_ch2;
	logic [7:0] right_ch0;
	logic [7:0] right_ch1;
	logic [7:0] right_ch2;
	logic       frame_end;

	modport source (
		output valid, left_ch0, left_ch1, left_ch2,
		output right_ch0, right_ch1, right_ch2, frame_end,
		input  ready
	);

	modport sink (
		input  valid, left_ch0, left_ch1, left_ch2,
		input  right_ch0, right_ch1, right_ch2, frame_end,
		output ready
	);
endinterface

### rtl/core/sdpm_res_if.sv
// ----------------------------------------------------------------------------
// sdpm_res_if
// Result channel: best shift, its display value and end of frame mark.
// ----------------------------------------------------------------------------
interface sdpm_res_if;
	logic       valid;
	logic       ready;
	logic [4:0] shift_index;
	logic [7:0] stretched_value;
	logic       frame_last;

	modport source (
		output valid, shift_index, stretched_value, frame_last,
		input  ready
	);

	modport sink (
		input  valid, shift_index, stretched_value, frame_last,
		output ready
	);
endinterface

### rtl/core/stereo_disparity_pixel_match_core.sv
// ----------------------------------------------------------------------------
// stereo_disparity_pixel_match_core
// Single-pixel stereo matcher over a raster stream of left/right RGB pairs.
// ----------------------------------------------------------------------------
// Each item brings one left and one right pixel; both are reduced to gray as
// floor((ch0+ch1+ch2)/3). The right gray of pixel i is matched against the
// left grays of pixels i .. i+NUM_SHIFTS-1 (raster order, crossing row ends),
// and the first shift with the strictly smallest absolute difference (start
// minimum 255) is returned together with shift*(256/NUM_SHIFTS). An item that
// does not complete a window is only written into the windows. An item that
// brings the NUM_SHIFTS-th pending pixel is accepted, compared once per window
// entry through the single compare unit, and emitted. An item with frame_end
// set flushes every pending pixel; for each result the compare unit scans all
// pixels still pending, then the result is emitted and the oldest pixel is
// dropped. The last result of a flush has frame_last set. Results sit in an
// output register, so the next item is accepted while a result waits; the core
// stalls only when a new result must go out while the previous one is still
// held.
// ----------------------------------------------------------------------------
module stereo_disparity_pixel_match_core #(
	parameter int NUM_SHIFTS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	sdpm_pix_if.sink   pix,
	sdpm_res_if.source res
);
	import sdpm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer: hands out load, compare-step and emit commands.
	sdpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Windows, compare unit and result register.
	sdpm_datapath #(
		.NUM_SHIFTS (NUM_SHIFTS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.left_ch0        (pix.left_ch0),
		.left_ch1        (pix.left_ch1),
		.left_ch2        (pix.left_ch2),
		.right_ch0       (pix.right_ch0),
		.right_ch1       (pix.right_ch1),
		.right_ch2       (pix.right_ch2),
		.frame_end       (pix.frame_end),
		.shift_index     (res.shift_index),
		.stretched_value (res.stretched_value),
		.frame_last      (res.frame_last)
	);

endmodule

### rtl/core/sdpm_datapath.sv
// ----------------------------------------------------------------------------
// sdpm_datapath
// Gray windows, pending count, the single compare unit that scans the
// window, and the result register.
// ----------------------------------------------------------------------------
module sdpm_datapath #(
	parameter int NUM_SHIFTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdpm_pkg::dp_cmd_t cmd,
	output sdpm_pkg::dp_stat_t stat,
	input  logic [7:0]        left_ch0,
	input  logic [7:0]        left_ch1,
	input  logic [7:0]        left_ch2,
	input  logic [7:0]        right_ch0,
	input  logic [7:0]        right_ch1,
	input  logic [7:0]        right_ch2,
	input  logic              frame_end,
	output logic [4:0]        shift_index,
	output logic [7:0]        stretched_value,
	output logic              frame_last
);
	import sdpm_pkg::*;

	localparam int IDX_W = $clog2(NUM_SHIFTS);
	localparam int CNT_W = $clog2(NUM_SHIFTS + 1);
	localparam logic [8:0] STRETCH = 9'(256 / NUM_SHIFTS);

	logic [7:0]       lwin_q [NUM_SHIFTS];
	logic [7:0]       rwin_q [NUM_SHIFTS];
	logic [CNT_W-1:0] fill_q;
	logic             flush_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] best_q;
	logic [7:0]       min_q;

	logic [7:0]  lgray, rgray;
	logic [7:0]  lcur, rref, diff;
	logic [16:0] stretch_prod;
	logic [15:0] best_ext;

	assign lgray = gray_of(left_ch0, left_ch1, left_ch2);
	assign rgray = gray_of(right_ch0, right_ch1, right_ch2);

	assign lcur = lwin_q[j_q];
	assign rref = rwin_q[0];
	assign diff = (lcur > rref) ? (lcur - rref) : (rref - lcur);

	assign best_ext     = 16'(best_q);
	assign stretch_prod = 17'(best_q) * 17'(STRETCH);

	always_comb begin
		stat.need_scan = frame_end || (fill_q == CNT_W'(NUM_SHIFTS - 1));
		stat.scan_last = (CNT_W'(j_q) == fill_q - CNT_W'(1));
		stat.more      = flush_q && (fill_q != CNT_W'(1));
	end

	// Windows: write at the fill position, shift down on drop.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lwin_q[fill_q[IDX_W-1:0]] <= lgray;
			rwin_q[fill_q[IDX_W-1:0]] <= rgray;
		end else if (cmd.emit) begin
			for (int k = 0; k < NUM_SHIFTS - 1; k++) begin
				lwin_q[k] <= lwin_q[k+1];
				rwin_q[k] <= rwin_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			flush_q <= 1'b0;
		end else if (cmd.load) begin
			fill_q  <= fill_q + CNT_W'(1);
			flush_q <= frame_end;
		end else if (cmd.emit) begin
			fill_q <= fill_q - CNT_W'(1);
			if (!stat.more) begin
				flush_q <= 1'b0;
			end
		end
	end

	// Scan state: restart on load and after each result.
	always_ff @(posedge clk) begin
		if (cmd.load || cmd.emit) begin
			j_q    <= '0;
			best_q <= '0;
			min_q  <= 8'hFF;
		end else if (cmd.step) begin
			j_q <= j_q + IDX_W'(1);
			if (diff < min_q) begin
				min_q  <= diff;
				best_q <= j_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			shift_index     <= best_ext[4:0];
			stretched_value <= stretch_prod[7:0];
			frame_last      <= flush_q && (fill_q == CNT_W'(1));
		end
	end

endmodule

### rtl/core/sdpm_ctrl.sv
// ----------------------------------------------------------------------------
// sdpm_ctrl
// Sequencer for the pixel match core: accept, scan the window, emit.
// ----------------------------------------------------------------------------
module sdpm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sdpm_pkg::dp_stat_t stat,
	output sdpm_pkg::dp_cmd_t  cmd
);
	import sdpm_pkg::*;

	ctrl_state_t state_q, state_next;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && stat.need_scan) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_next = stat.more ? ST_SCAN : ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: cmd.step = 1'b1;
			ST_EMIT: cmd.emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
